// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/dfq_pkg.sv -----
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared constants and types of the DCT feature quantizer.
// ----------------------------------------------------------------------------
package dfq_pkg;

    // Default configuration of the block
    localparam int FEATURE_COUNT_DEF = 9;
    localparam int COEFF_BITS_DEF    = 24;

    // Field widths
    localparam int QL_W     = 6;
    localparam int FEAT_W   = 7;
    localparam int FIDX_W   = 4;
    localparam int NORM_W   = 16;
    localparam int Q_W      = 6;
    localparam int ROOT_W   = 16;
    localparam int RAD_W    = 32;
    localparam int SQSUM_W  = 16;

    // Quotient never exceeds quant_level, so six restoring steps suffice
    localparam int DIV_STEPS  = Q_W;
    localparam int SQRT_STEPS = ROOT_W;

    // Floor of the running maximum magnitude (about 0.01 in Q15.8)
    localparam int MAG_FLOOR = 3;

    // Register file
    localparam int          PADDR_W            = 3;
    localparam int          PDATA_W            = 32;
    localparam logic        REG_IDX_QUANT_LEVEL = 1'b0;
    localparam logic [QL_W-1:0] QUANT_LEVEL_RESET = 6'd20;

    // Operation of the shared divide / square-root unit
    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } dfq_op_t;

    typedef struct packed {
        logic    start;
        dfq_op_t op;
    } dfq_unit_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] result;
    } dfq_unit_status_t;

endpackage

// ----- rtl/core/dct_feature_quantizer.sv -----
// Sequence: one beat per coefficient; after the last one, each feature is
// multiplied, passed through the 6-step divide and emitted, and the last one
// also takes the 16-step square root before its emit; output stalls hold the
// emit. Pace is set by the shared bit-serial divide/sqrt unit.
// Reset (rst_n low, async): maximum returns to 3, counters and sums to 0,
// quant_level to 20, and the block waits for the first coefficient.
// ----------------------------------------------------------------------------
// dct_feature_quantizer
// Collects a block of DCT coefficients and emits normalized quantized features
// with the Euclidean norm of the quantized features on the last one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dct_feature_quantizer #(
    parameter int FEATURE_COUNT = dfq_pkg::FEATURE_COUNT_DEF,
    parameter int COEFF_BITS    = dfq_pkg::COEFF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfq_pkg::PADDR_W-1:0]   paddr,
    input  logic [dfq_pkg::PDATA_W-1:0]   pwdata,
    output logic [dfq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // coefficient channel
    input  logic                          coeff_valid,
    output logic                          coeff_ready,
    input  logic signed [COEFF_BITS-1:0]  coeff,
    // feature channel
    output logic                          feature_valid,
    input  logic                          feature_ready,
    output logic signed [dfq_pkg::FEAT_W-1:0] feature,
    output logic [dfq_pkg::FIDX_W-1:0]    feature_index,
    output logic [dfq_pkg::NORM_W-1:0]    norm,
    output logic                          last
);

    import dfq_pkg::*;

    localparam int IDX_W = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int UW    = COEFF_BITS + 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [FIDX_W-1:0]     idx_reg;
    logic [FIDX_W-1:0]     idx_next;
    logic [UW-1:0]         num_reg;
    logic [UW-1:0]         num_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [SQSUM_W-1:0]    sqsum_reg;
    logic [SQSUM_W-1:0]    sqsum_next;
    logic [FEAT_W-1:0]     feature_reg;
    logic [FEAT_W-1:0]     feature_next;
    logic [FIDX_W-1:0]     findex_reg;
    logic [FIDX_W-1:0]     findex_next;
    logic [NORM_W-1:0]     norm_reg;
    logic [NORM_W-1:0]     norm_next;
    logic                  last_reg;
    logic                  last_next;
    logic [QL_W-1:0]       quant_level_reg;

    logic                  load;
    logic                  clear;
    logic [COEFF_BITS-1:0] rd_mag;
    logic                  rd_neg;
    logic [COEFF_BITS-1:0] max_mag;
    logic                  last_load;
    logic [UW-1:0]         dividend;
    logic [COEFF_BITS:0]   divisor;
    logic [FEAT_W-1:0]     q_ext;
    logic [2*Q_W-1:0]      q_sq;
    dfq_unit_req_t         unit_req;
    dfq_unit_status_t      unit_status;

    // Configuration register: writes take effect on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_QUANT_LEVEL) ? PDATA_W'(quant_level_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_level_reg <= QUANT_LEVEL_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_QUANT_LEVEL))
        begin
            quant_level_reg <= pwdata[QL_W-1:0];
        end
    end

    // Coefficient store and running maximum
    assign load  = coeff_valid && coeff_ready;
    assign clear = (state_reg == ST_EMIT) && feature_ready && last_reg;

    dfq_collect #(
        .FEATURE_COUNT (FEATURE_COUNT),
        .COEFF_BITS    (COEFF_BITS),
        .IDX_W         (IDX_W)
    ) u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .coeff     (coeff),
        .clear     (clear),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_mag    (rd_mag),
        .rd_neg    (rd_neg),
        .max_mag   (max_mag),
        .last_load (last_load)
    );

    // Rounded division: (2*m*L + max) / (2*max)
    assign dividend = UW'({num_reg, 1'b0}) + UW'(max_mag);
    assign divisor  = {max_mag, 1'b0};

    assign unit_req.start = (state_reg == ST_DIV_GO) || (state_reg == ST_SQRT_GO);
    assign unit_req.op    = (state_reg == ST_SQRT_GO) ? OP_SQRT : OP_DIV;

    dfq_divsqrt #(
        .COEFF_BITS (COEFF_BITS),
        .UW         (UW)
    ) u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (unit_req),
        .dividend (dividend),
        .divisor  (divisor),
        .radicand ({sqsum_reg, 16'b0}),
        .status   (unit_status)
    );

    assign q_ext = {1'b0, unit_status.result[Q_W-1:0]};
    assign q_sq  = (2*Q_W)'(unit_status.result[Q_W-1:0])
                 * (2*Q_W)'(unit_status.result[Q_W-1:0]);

    // Sequencer: multiply, divide, emit each feature; square root before the last
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        num_next     = num_reg;
        neg_next     = neg_reg;
        sqsum_next   = sqsum_reg;
        feature_next = feature_reg;
        findex_next  = findex_reg;
        norm_next    = norm_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load && last_load)
                begin
                    idx_next   = '0;
                    sqsum_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                num_next   = UW'(rd_mag) * UW'(quant_level_reg);
                neg_next   = rd_neg;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (unit_status.done)
                begin
                    feature_next = neg_reg ? (FEAT_W'(0) - q_ext) : q_ext;
                    sqsum_next   = sqsum_reg + SQSUM_W'(q_sq);
                    findex_next  = idx_reg;
                    norm_next    = '0;
                    if (idx_reg == FIDX_W'(FEATURE_COUNT - 1))
                    begin
                        last_next  = 1'b1;
                        state_next = ST_SQRT_GO;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SQRT_GO:
            begin
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (unit_status.done)
                begin
                    norm_next  = unit_status.result;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (feature_ready)
                begin
                    if (last_reg)
                    begin
                        sqsum_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold state and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            idx_reg     <= '0;
            num_reg     <= '0;
            neg_reg     <= 1'b0;
            sqsum_reg   <= '0;
            feature_reg <= '0;
            findex_reg  <= '0;
            norm_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            num_reg     <= num_next;
            neg_reg     <= neg_next;
            sqsum_reg   <= sqsum_next;
            feature_reg <= feature_next;
            findex_reg  <= findex_next;
            norm_reg    <= norm_next;
            last_reg    <= last_next;
        end
    end

    assign coeff_ready   = (state_reg == ST_LOAD);
    assign feature_valid = (state_reg == ST_EMIT);
    assign feature       = feature_reg;
    assign feature_index = findex_reg;
    assign norm          = norm_reg;
    assign last          = last_reg;

    // Checks on sequencing and output framing
    `ASSERT_IMP(a_last_index, clk, rst_n, feature_valid && last,
                feature_index == FIDX_W'(FEATURE_COUNT - 1))
    `ASSERT_IMP(a_norm_only_last, clk, rst_n, feature_valid && !last, norm == '0)
    `ASSERT_IMP(a_done_when_waiting, clk, rst_n, unit_status.done,
                state_reg == ST_DIV_WAIT || state_reg == ST_SQRT_WAIT)
    `ASSERT_NEXT(a_restart_after_last, clk, rst_n, feature_valid && feature_ready && last,
                 coeff_ready && !feature_valid)

endmodule

// ----- rtl/core/dfq_collect.sv -----
// ----------------------------------------------------------------------------
// dfq_collect
// Coefficient buffer, load counter and running maximum magnitude.
// ----------------------------------------------------------------------------
module dfq_collect #(
    parameter int FEATURE_COUNT = dfq_pkg::FEATURE_COUNT_DEF,
    parameter int COEFF_BITS    = dfq_pkg::COEFF_BITS_DEF,
    parameter int IDX_W         = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [COEFF_BITS-1:0] coeff,
    input  logic                  clear,
    input  logic [IDX_W-1:0]      rd_idx,
    output logic [COEFF_BITS-1:0] rd_mag,
    output logic                  rd_neg,
    output logic [COEFF_BITS-1:0] max_mag,
    output logic                  last_load
);

    import dfq_pkg::*;

    logic [COEFF_BITS-1:0] buf_reg [FEATURE_COUNT];
    logic [FIDX_W-1:0]     load_cnt_reg;
    logic [FIDX_W-1:0]     load_cnt_next;
    logic [COEFF_BITS-1:0] max_reg;
    logic [COEFF_BITS-1:0] max_next;
    logic [COEFF_BITS-1:0] in_mag;
    logic [COEFF_BITS-1:0] rd_coeff;

    // Magnitude of the incoming beat, most negative value stays unsigned
    assign in_mag = coeff[COEFF_BITS-1] ? (~coeff + 1'b1) : coeff;

    assign last_load = (load_cnt_reg == FIDX_W'(FEATURE_COUNT - 1));

    // Advance count and maximum on load, drop back to floor on clear
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        max_next      = max_reg;
        if (clear)
        begin
            load_cnt_next = '0;
            max_next      = COEFF_BITS'(MAG_FLOOR);
        end
        else if (load)
        begin
            load_cnt_next = last_load ? '0 : load_cnt_reg + 1'b1;
            if (in_mag > max_reg)
            begin
                max_next = in_mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            max_reg      <= COEFF_BITS'(MAG_FLOOR);
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            max_reg      <= max_next;
        end
    end

    // Store the beat at the current slot
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg[load_cnt_reg[IDX_W-1:0]] <= coeff;
        end
    end

    // Read side: sign and magnitude of the selected entry
    assign rd_coeff = buf_reg[rd_idx];
    assign rd_neg   = rd_coeff[COEFF_BITS-1];
    assign rd_mag   = rd_neg ? (~rd_coeff + 1'b1) : rd_coeff;
    assign max_mag  = max_reg;

endmodule

// ----- rtl/core/dfq_divsqrt.sv -----
// ----------------------------------------------------------------------------
// dfq_divsqrt
// Shared restoring divide and square-root unit, one bit per cycle.
// ----------------------------------------------------------------------------
module dfq_divsqrt #(
    parameter int COEFF_BITS = dfq_pkg::COEFF_BITS_DEF,
    parameter int UW         = COEFF_BITS + 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfq_pkg::dfq_unit_req_t      req,
    input  logic [UW-1:0]               dividend,
    input  logic [COEFF_BITS:0]         divisor,
    input  logic [dfq_pkg::RAD_W-1:0]   radicand,
    output dfq_pkg::dfq_unit_status_t   status
);

    import dfq_pkg::*;

    logic [UW-1:0]     rem_reg;
    logic [UW-1:0]     rem_next;
    logic [UW-1:0]     dsr_reg;
    logic [UW-1:0]     dsr_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [RAD_W-1:0]  rad_reg;
    logic [RAD_W-1:0]  rad_next;
    logic [3:0]        cnt_reg;
    logic [3:0]        cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    dfq_op_t           op_reg;
    dfq_op_t           op_next;

    logic [UW-1:0]     rem_shift;
    logic [UW-1:0]     trial;
    logic [UW-1:0]     cmp_a;
    logic [UW-1:0]     cmp_b;
    logic [UW:0]       diff;
    logic              ge;
    logic              round_up;

    // Operands of the shared compare-subtract
    assign rem_shift = {rem_reg[UW-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = UW'({root_reg, 2'b01});
    assign cmp_a     = (op_reg == OP_SQRT) ? rem_shift : rem_reg;
    assign cmp_b     = (op_reg == OP_SQRT) ? trial : dsr_reg;
    assign diff      = {1'b0, cmp_a} - {1'b0, cmp_b};
    assign ge        = !diff[UW];

    // Load on start, else take one step per cycle while busy
    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        root_next = root_reg;
        rad_next  = rad_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            root_next = '0;
            rad_next  = radicand;
            if (req.op == OP_SQRT)
            begin
                rem_next = '0;
                cnt_next = 4'(SQRT_STEPS - 1);
            end
            else
            begin
                rem_next = dividend;
                dsr_next = {divisor, 5'b0};
                cnt_next = 4'(DIV_STEPS - 1);
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[UW-1:0] : cmp_a;
            root_next = {root_reg[ROOT_W-2:0], ge};
            dsr_next  = dsr_reg >> 1;
            rad_next  = rad_reg << 2;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    // Round the root to nearest when the leftover exceeds the root
    assign round_up = (op_reg == OP_SQRT) && (rem_reg > UW'(root_reg));

    assign status.done   = done_reg;
    assign status.result = root_reg + ROOT_W'(round_up);

endmodule
